/* hdl/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam logic [2:0] CMD_RED = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic signed [1:0] ORD_LT = -2'sd1;
    localparam logic signed [1:0] ORD_EQ = 2'sd0;
    localparam logic signed [1:0] ORD_GT = 2'sd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_PREP,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

endpackage

/* hdl/rau_div.sv */
`timescale 1ns / 1ps
module rau_div #(
    parameter int MW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_dividend,
    input  logic [MW-1:0] i_divisor,
    output logic          o_done,
    output logic [MW-1:0] o_quotient
);
    localparam int CW = $clog2(MW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW:0]   r_rem;
    logic [MW-1:0] r_quo;
    logic [MW-1:0] r_dvs;
    logic [MW:0]   w_sh;
    logic [MW:0]   w_sub;
    logic          w_ge;

    assign w_sh  = {r_rem[MW-1:0], r_quo[MW-1]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub : w_sh;
            r_quo <= {r_quo[MW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* hdl/rau_gcd.sv */
`timescale 1ns / 1ps
module rau_gcd #(
    parameter int MW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [MW-1:0] o_gcd
);
    localparam int KW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_k;
    logic [MW-1:0] r_a;
    logic [MW-1:0] r_b;
    logic [MW-1:0] r_g;
    logic          w_fin;

    assign w_fin = (r_a == '0) || (r_b == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_fin) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            if (w_fin) begin
                r_g <= (r_a | r_b) << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;
endmodule

/* hdl/rational_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply, divide, compare two
// signed fractions, or reduce the first one, fraction results in lowest terms.
// Input channel: i_valid/o_ready carrying command and four operands.
// Output channel: o_valid/i_ready carrying res_num, res_den, order, status.
// One request at a time: o_ready is high only while the sequencer is idle.
// Steps: zero denominator or divide by zero go straight to the done
//   state; compare runs S_MUL0, S_MUL1, S_PREP; other commands run S_MUL0,
//   S_MUL1 (and S_MUL2 for add and subtract), S_PREP, a binary GCD, then
//   two restoring divisions by the GCD, numerator then denominator, all
//   on MW = 2*OPERAND_WIDTH+3 bits.
// The GCD loop and the bit-serial divider set the item time; a single
// shared multiplier forms the cross products over successive cycles.
// Reset (synchronous, active low) empties the sequencer and the output
// register. When the receiver stalls, the result stays in the output
// register and a new request is still taken; the next finished result
// waits in its final state until the output register frees.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_command,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_den,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rau_pkg::RES_NUM_W-1:0] o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]       o_res_den,
    output logic signed [1:0]                   o_order,
    output logic [1:0]                          o_status
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH + 1;
    localparam int PW = 2 * OW;
    localparam int SW = PW + 1;
    localparam int MW = SW;
    localparam int XW = (MW + 1 > RES_NUM_W) ? MW + 1 : RES_NUM_W;

    t_state r_state, n_state;

    logic [2:0]           r_cmd;
    logic signed [OW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [OW-1:0] w_an, w_ad, w_bn, w_bd;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [OW-1:0] w_mx, w_my;
    logic signed [PW-1:0] w_prod;
    logic signed [SW-1:0] w_n, w_d;
    logic [MW-1:0]        w_mag_n, w_mag_d;
    logic [MW-1:0]        r_mn, r_md, r_qn;
    logic                 r_neg;
    logic [2:0]           w_cmd;
    logic                 w_acc, w_bad, w_divz, w_out_free;

    logic signed [RES_NUM_W-1:0] r_rn;
    logic [RES_DEN_W-1:0]        r_rd;
    logic signed [1:0]           r_ord;
    logic [1:0]                  r_st;

    logic                        r_ov;
    logic signed [RES_NUM_W-1:0] r_o_num;
    logic [RES_DEN_W-1:0]        r_o_den;
    logic signed [1:0]           r_o_ord;
    logic [1:0]                  r_o_st;

    logic          w_gcd_start, w_gcd_done;
    logic [MW-1:0] w_gcd;
    logic          w_div_start, w_div_done;
    logic [MW-1:0] w_div_a, w_quo;
    logic signed [MW:0]   w_sq;
    logic signed [XW-1:0] w_xn;
    logic [XW-1:0]        w_xd;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_out_free = !r_ov || i_ready;

    assign w_cmd  = (i_command > CMD_RED) ? CMD_RED : i_command;
    assign w_bad  = (i_a_den == '0) || ((w_cmd != CMD_RED) && (i_b_den == '0));
    assign w_divz = (w_cmd == CMD_DIV) && (i_b_num == '0);

    always_comb begin
        w_an = OW'(i_a_num);
        w_ad = OW'(i_a_den);
        w_bn = OW'(i_b_num);
        w_bd = OW'(i_b_den);
        if (i_a_den < 0) begin
            w_an = -w_an;
            w_ad = -w_ad;
        end
        if (i_b_den < 0) begin
            w_bn = -w_bn;
            w_bd = -w_bd;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) n_state = (w_bad || w_divz) ? S_DONE : S_MUL0;
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: begin
                n_state = (r_cmd == CMD_ADD || r_cmd == CMD_SUB) ? S_MUL2 : S_PREP;
            end
            S_MUL2: n_state = S_PREP;
            S_PREP: n_state = (r_cmd == CMD_CMP) ? S_DONE : S_GCD;
            S_GCD:  if (w_gcd_done) n_state = S_DIVN;
            S_DIVN: if (w_div_done) n_state = S_DIVD;
            S_DIVD: if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mx        = r_ad;
        w_my        = r_bd;
        w_gcd_start = 1'b0;
        w_div_start = 1'b0;
        w_div_a     = r_md;
        case (r_state)
            S_MUL0: begin
                w_mx = r_an;
                case (r_cmd)
                    CMD_MUL: w_my = r_bn;
                    CMD_RED: w_my = OW'(1);
                    default: w_my = r_bd;
                endcase
            end
            S_MUL1: begin
                w_mx = r_ad;
                case (r_cmd)
                    CMD_MUL: w_my = r_bd;
                    CMD_RED: w_my = OW'(1);
                    default: w_my = r_bn;
                endcase
            end
            S_PREP: w_gcd_start = (r_cmd != CMD_CMP);
            S_GCD: begin
                w_div_start = w_gcd_done;
                w_div_a     = r_mn;
            end
            S_DIVN: w_div_start = w_div_done;
            default: ;
        endcase
    end

    assign w_prod = w_mx * w_my;

    always_comb begin
        case (r_cmd)
            CMD_ADD: begin
                w_n = SW'(r_p0) + SW'(r_p1);
                w_d = SW'(r_p2);
            end
            CMD_SUB: begin
                w_n = SW'(r_p0) - SW'(r_p1);
                w_d = SW'(r_p2);
            end
            default: begin
                w_n = SW'(r_p0);
                w_d = SW'(r_p1);
            end
        endcase
    end

    assign w_mag_n = MW'(w_n[SW-1] ? -w_n : w_n);
    assign w_mag_d = MW'(w_d[SW-1] ? -w_d : w_d);

    assign w_sq = r_neg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});
    assign w_xn = XW'(w_sq);
    assign w_xd = XW'(w_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_cmd <= w_cmd;
                    r_an  <= w_an;
                    r_ad  <= w_ad;
                    r_bn  <= w_bn;
                    r_bd  <= w_bd;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_ord <= ORD_EQ;
                    r_st  <= w_bad ? ST_ZERO_DEN : (w_divz ? ST_DIV_ZERO : ST_OK);
                end
            end
            S_MUL0: r_p0 <= w_prod;
            S_MUL1: r_p1 <= w_prod;
            S_MUL2: r_p2 <= w_prod;
            S_PREP: begin
                r_neg <= w_n[SW-1] ^ w_d[SW-1];
                r_mn  <= w_mag_n;
                r_md  <= w_mag_d;
                if (r_cmd == CMD_CMP) begin
                    r_ord <= (r_p0 > r_p1) ? ORD_GT : ((r_p0 < r_p1) ? ORD_LT : ORD_EQ);
                end
            end
            S_DIVN: if (w_div_done) r_qn <= w_quo;
            S_DIVD: begin
                if (w_div_done) begin
                    r_rn <= w_xn[RES_NUM_W-1:0];
                    r_rd <= w_xd[RES_DEN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_num <= r_rn;
            r_o_den <= r_rd;
            r_o_ord <= r_ord;
            r_o_st  <= r_st;
        end
    end

    rau_gcd #(.MW(MW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (w_mag_n),
        .i_b     (w_mag_d),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    rau_div #(.MW(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_gcd),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_valid   = r_ov;
    assign o_res_num = r_o_num;
    assign o_res_den = r_o_den;
    assign o_order   = r_o_ord;
    assign o_status  = r_o_st;
endmodule

/* hdl/rau_chk.sv */
`timescale 1ns / 1ps
module rau_chk #(
    parameter int OPERAND_WIDTH = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [rau_pkg::RES_NUM_W-1:0] o_res_num,
    input logic [rau_pkg::RES_DEN_W-1:0]       o_res_den,
    input logic signed [1:0]                   o_order,
    input logic [1:0]                          o_status
);
    import rau_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_res_num) && $stable(o_res_den)
            && $stable(o_status) && $stable(o_order))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_res_num == '0 && o_res_den == '0
            && o_order == ORD_EQ)
        else $error("error result not cleared");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_order != ORD_EQ |-> o_res_den == '0 && o_status == ST_OK)
        else $error("compare result carries a fraction");
endmodule

bind rational_arithmetic_unit_top rau_chk #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_res_num (o_res_num),
    .o_res_den (o_res_den),
    .o_order   (o_order),
    .o_status  (o_status)
);
